### src/wsfr_pkg.sv
// Shared types and constants for the WebSocket frame receiver.
package wsfr_pkg;

	// Frame header bytes and the length flip pattern
	localparam logic [7:0] HDR_TEXT  = 8'h81;
	localparam logic [7:0] HDR_PONG  = 8'h8A;
	localparam logic [7:0] HDR_CLOSE = 8'h88;
	localparam logic [7:0] LEN_FLIP  = 8'h80;

	// Timer and register widths
	localparam int unsigned TIMER_W = 17;
	localparam int unsigned CFG_W   = 16;
	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
	localparam logic [CFG_W-1:0] PONG_GRACE_RESET = 16'd500;

	// Register indexes on the configuration port
	localparam logic CFG_PING_INTERVAL = 1'b0;
	localparam logic CFG_PONG_GRACE    = 1'b1;

	// Result queue geometry
	localparam int unsigned RES_DEPTH = 8;
	localparam int unsigned RES_AW    = $clog2(RES_DEPTH);
	localparam int unsigned RES_CW    = $clog2(RES_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_BYTE = 2'd1,
		ACT_OPEN = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_LENGTH  = 4'b0010,
		PH_MASK    = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		FK_TEXT  = 2'd0,
		FK_PONG  = 2'd1,
		FK_CLOSE = 2'd2
	} frame_kind_t;

	typedef enum logic [2:0] {
		K_BYTE    = 3'd0,
		K_EMPTY   = 3'd1,
		K_PING    = 3'd2,
		K_CLOSE   = 3'd3,
		K_TIMEOUT = 3'd4
	} res_kind_t;

	typedef struct packed {
		res_kind_t   kind;
		logic [7:0]  data;
		logic        last;
		logic        from_pong;
	} result_t;

endpackage

### src/wsfr_parser.sv
// Frame parser, unmasker and keepalive timers: one registered item per cycle.
module wsfr_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic [1:0]                    action,
	input  logic [7:0]                    rx_byte,
	input  logic [wsfr_pkg::CFG_W-1:0]    ping_interval,
	input  logic [wsfr_pkg::CFG_W-1:0]    pong_grace,
	output logic [1:0]                    res_count,
	output wsfr_pkg::result_t             res0,
	output wsfr_pkg::result_t             res1
);
	import wsfr_pkg::*;

	phase_t              phase_q, phase_d;
	frame_kind_t         fkind_q, fkind_d;
	logic [7:0]          remain_q, remain_d;
	logic [1:0]          pos_q, pos_d;
	logic [TIMER_W-1:0]  since_ping_q, since_ping_d;
	logic [TIMER_W-1:0]  since_pong_q, since_pong_d;
	logic                connected_q, connected_d;
	logic [7:0]          mask_q [4];

	logic                mask_we;
	logic [TIMER_W-1:0]  ping_inc, pong_inc, pong_limit;
	logic [7:0]          len_val, remain_dec, unmasked;
	logic [1:0]          pos_inc;
	logic                pong_flag;

	// Saturating timer steps and the pong deadline
	assign ping_inc   = (since_ping_q == TIMER_MAX) ? TIMER_MAX : since_ping_q + 1'b1;
	assign pong_inc   = (since_pong_q == TIMER_MAX) ? TIMER_MAX : since_pong_q + 1'b1;
	assign pong_limit = {1'b0, ping_interval} + {1'b0, pong_grace};
	assign len_val    = rx_byte ^ LEN_FLIP;
	assign remain_dec = (remain_q != 8'd0) ? remain_q - 8'd1 : remain_q;
	assign pos_inc    = pos_q + 2'd1;
	assign unmasked   = mask_q[pos_q] ^ rx_byte;
	assign pong_flag  = (fkind_q == FK_PONG);

	// Next state and results for the item in the input register
	always_comb begin
		phase_d      = phase_q;
		fkind_d      = fkind_q;
		remain_d     = remain_q;
		pos_d        = pos_q;
		since_ping_d = since_ping_q;
		since_pong_d = since_pong_q;
		connected_d  = connected_q;
		mask_we      = 1'b0;
		res_count    = 2'd0;
		res0         = '{kind: K_BYTE, data: 8'd0, last: 1'b1, from_pong: 1'b0};
		res1         = '{kind: K_BYTE, data: 8'd0, last: 1'b1, from_pong: 1'b0};
		if (item_valid) begin
			case (action)
				ACT_TICK: begin
					if (connected_q) begin
						since_ping_d = ping_inc;
						since_pong_d = pong_inc;
						if (ping_interval != '0) begin
							if (ping_inc > {1'b0, ping_interval}) begin
								since_ping_d = '0;
								res0.kind    = K_PING;
								res_count    = 2'd1;
							end
							if (pong_inc > pong_limit) begin
								if (res_count == 2'd1) begin
									res1.kind = K_TIMEOUT;
								end else begin
									res0.kind = K_TIMEOUT;
								end
								res_count   = res_count + 2'd1;
								connected_d = 1'b0;
								phase_d     = PH_HEADER;
								remain_d    = 8'd0;
								pos_d       = 2'd0;
							end
						end
					end
				end
				ACT_BYTE: begin
					if (connected_q) begin
						case (phase_q)
							PH_HEADER: begin
								if (rx_byte == HDR_TEXT) begin
									fkind_d      = FK_TEXT;
									since_ping_d = '0;
									since_pong_d = '0;
									phase_d      = PH_LENGTH;
								end else if (rx_byte == HDR_PONG) begin
									fkind_d      = FK_PONG;
									since_pong_d = '0;
									phase_d      = PH_LENGTH;
								end else if (rx_byte == HDR_CLOSE) begin
									fkind_d = FK_CLOSE;
									phase_d = PH_LENGTH;
								end
							end
							PH_LENGTH: begin
								remain_d = len_val;
								pos_d    = 2'd0;
								if (fkind_q == FK_CLOSE && len_val == 8'd0) begin
									res0.kind   = K_CLOSE;
									res_count   = 2'd1;
									connected_d = 1'b0;
									phase_d     = PH_HEADER;
								end else begin
									phase_d = PH_MASK;
								end
							end
							PH_MASK: begin
								mask_we = 1'b1;
								pos_d   = pos_inc;
								if (pos_inc == 2'd0) begin
									if (remain_q != 8'd0) begin
										phase_d = PH_PAYLOAD;
									end else if (fkind_q == FK_CLOSE) begin
										res0.kind   = K_CLOSE;
										res_count   = 2'd1;
										connected_d = 1'b0;
										phase_d     = PH_HEADER;
										remain_d    = 8'd0;
									end else begin
										res0.kind      = K_EMPTY;
										res0.from_pong = pong_flag;
										res_count      = 2'd1;
										phase_d        = PH_HEADER;
									end
								end
							end
							PH_PAYLOAD: begin
								pos_d    = pos_inc;
								remain_d = remain_dec;
								if (remain_dec == 8'd0) begin
									phase_d = PH_HEADER;
								end
								if (fkind_q == FK_CLOSE) begin
									if (remain_dec == 8'd0) begin
										res0.kind   = K_CLOSE;
										res_count   = 2'd1;
										connected_d = 1'b0;
										pos_d       = 2'd0;
									end
								end else begin
									res0.kind      = K_BYTE;
									res0.data      = unmasked;
									res0.last      = (remain_dec == 8'd0);
									res0.from_pong = pong_flag;
									res_count      = 2'd1;
								end
							end
							default: begin
								phase_d = PH_HEADER;
							end
						endcase
					end
				end
				ACT_OPEN: begin
					connected_d  = 1'b1;
					since_ping_d = '0;
					since_pong_d = '0;
					phase_d      = PH_HEADER;
					remain_d     = 8'd0;
					pos_d        = 2'd0;
				end
				default: begin
				end
			endcase
		end
	end

	// Hold parser state and timers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			fkind_q      <= FK_TEXT;
			remain_q     <= 8'd0;
			pos_q        <= 2'd0;
			since_ping_q <= '0;
			since_pong_q <= '0;
			connected_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			fkind_q      <= fkind_d;
			remain_q     <= remain_d;
			pos_q        <= pos_d;
			since_ping_q <= since_ping_d;
			since_pong_q <= since_pong_d;
			connected_q  <= connected_d;
		end
	end

	// Capture mask key bytes
	always_ff @(posedge clk) begin
		if (mask_we) begin
			mask_q[pos_q] <= rx_byte;
		end
	end

endmodule

### src/wsfr_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transaction.
module wsfr_res_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_count,
	input  wsfr_pkg::result_t             push0,
	input  wsfr_pkg::result_t             push1,
	input  logic                          pop,
	output logic [wsfr_pkg::RES_CW-1:0]   level,
	output wsfr_pkg::result_t             head
);
	import wsfr_pkg::*;

	result_t            mem_q [RES_DEPTH];
	logic [RES_AW-1:0]  wr_q, rd_q;
	logic [RES_CW-1:0]  level_q;
	logic [RES_AW-1:0]  wr_next;

	assign wr_next = wr_q + 1'b1;
	assign level   = level_q;
	assign head    = mem_q[rd_q];

	// Write one or two entries
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_next] <= push1;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_AW'(push_count);
			rd_q    <= rd_q + RES_AW'(pop);
			level_q <= level_q + RES_CW'(push_count) - RES_CW'(pop);
		end
	end

endmodule

### src/websocket_frame_receiver.sv
// Top level of the WebSocket frame receiver: input register, parser, result queue.
//
//  Channel | Direction | Signals                       | Contents
//  s_*     | in        | s_tvalid s_tready s_tdata s_tuser | tick, byte or link-open item
//  m_*     | out       | m_tvalid m_tready m_tdata m_tlast m_tuser | message byte or event
//  cfg_*   | in        | cfg_we cfg_index cfg_data     | ping interval, pong grace
//
// One item is accepted per cycle while s_tready is high; it is registered, decoded in the
// next cycle and its zero to two results land in an eight-entry queue, from whose head they
// leave on m_*. A tick may give a ping and a timeout, which leave on two successive
// transactions. s_tready drops only when the queue cannot take two more results for a new
// item and, if one is registered, two for the registered item as well. Reset clears the
// parser, timers and queue, leaves the link closed and the mask key unknown.
module websocket_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data
	output logic        m_tlast,
	output logic [3:0]  m_tuser,   // [2:0] kind, [3] from_pong
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import wsfr_pkg::*;

	logic               item_valid_s1;
	logic [1:0]         action_s1;
	logic [7:0]         byte_s1;
	logic [CFG_W-1:0]   ping_interval_q, pong_grace_q;
	logic [1:0]         res_count;
	result_t            res0, res1, head;
	logic [RES_CW-1:0]  level;
	logic [RES_CW:0]    need;
	logic               pop;

	// Room for two results each for the registered item, if any, and one more
	assign need     = {1'b0, level} + (item_valid_s1 ? (RES_CW+1)'(4) : (RES_CW+1)'(2));
	assign s_tready = (need <= (RES_CW+1)'(RES_DEPTH));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_interval_q <= '0;
			pong_grace_q    <= PONG_GRACE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PING_INTERVAL: ping_interval_q <= cfg_data;
				CFG_PONG_GRACE:    pong_grace_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else begin
			item_valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	wsfr_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid_s1),
		.action        (action_s1),
		.rx_byte       (byte_s1),
		.ping_interval (ping_interval_q),
		.pong_grace    (pong_grace_q),
		.res_count     (res_count),
		.res0          (res0),
		.res1          (res1)
	);

	assign pop = m_tvalid && m_tready;

	wsfr_res_fifo u_res_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (res_count),
		.push0      (res0),
		.push1      (res1),
		.pop        (pop),
		.level      (level),
		.head       (head)
	);

	// Drive the result stream from the queue head
	assign m_tvalid = (level != '0);
	assign m_tdata  = head.data;
	assign m_tlast  = head.last;
	assign m_tuser  = {head.from_pong, head.kind};

endmodule
